[rtl/bsa_pkg.sv]
// Package: shared types and codes of the banker's safety allocator.
`timescale 1ns / 1ps
`default_nettype none
package bsa_pkg;

   typedef enum logic [2:0] {
      CMD_LOAD_MAX   = 3'd0,
      CMD_LOAD_ALLOC = 3'd1,
      CMD_LOAD_AVAIL = 3'd2,
      CMD_SAFETY     = 3'd3,
      CMD_REQUEST    = 3'd4
   } command_type;

   typedef enum logic [2:0] {
      ST_STORED   = 3'd0,
      ST_SAFE     = 3'd1,
      ST_UNSAFE   = 3'd2,
      ST_EXCEEDS  = 3'd3,
      ST_BLOCKED  = 3'd4,
      ST_BAD_PROC = 3'd5
   } status_type;

   localparam logic [0:0] CSR_PROCESS_COUNT  = 1'b0;
   localparam logic [0:0] CSR_RESOURCE_COUNT = 1'b1;

   typedef enum logic [4:0] {
      S_IDLE,
      S_LOAD,
      S_CHK_RD,
      S_CHK_NEED,
      S_CHK_AVAIL,
      S_TRIAL,
      S_SRCH_INIT,
      S_SRCH_RD,
      S_SRCH_CMP,
      S_SRCH_ADD_RD,
      S_SRCH_ADD,
      S_SRCH_NEXT,
      S_SRCH_END,
      S_ROLLBACK,
      S_SEQ_RD,
      S_SEQ_OUT,
      S_SINGLE,
      S_WAIT_OUT,
      S_CLEAR
   } fsm_state_type;

   // Controller commands to the datapath.
   typedef struct packed {
      logic clr_write;     // write zero to both tables at the clearing counter
      logic capture_req;   // take the input transaction into holding registers
      logic do_load;       // write the addressed table entry
      logic clr_req_buf;   // clear the request buffer
      logic set_rd;        // present cell (proc, res) to the table RAMs
      logic res_clr;       // resource counter to zero
      logic res_inc;       // resource counter up by one
      logic proc_clr;      // process counter to zero
      logic proc_inc;      // process counter up by one
      logic use_req_proc;  // address process from the request
      logic trial_write;   // commit request to allocated and available
      logic roll_write;    // undo the request
      logic work_init;     // copy available into work vector at res counter
      logic work_add;      // add allocated into work vector at res counter
      logic fin_clr;       // clear finished flags and done count
      logic fin_set;       // mark process, append to safe order
      logic fits_clr;      // start a new fits test
      logic fits_cmp;      // fold one compare into fits test
      logic found_clr;
      logic seq_clr;       // sequence index to zero
      logic seq_inc;
      logic out_load;      // load output register
      status_type out_status;
      logic out_from_seq;  // seq_process from safe order
   } dp_cmd_type;

   typedef struct packed {
      command_type cmd;
      logic        clr_done;     // clearing counter on the last table cell
      logic        proc_bad;
      logic        last_res;     // resource counter on last used class
      logic        last_proc;    // process counter on last used process
      logic        need_bad;     // request exceeds need at current class
      logic        avail_bad;    // request exceeds available at current class
      logic        fits;         // fits test still true
      logic        fits_now;     // current compare passes
      logic        finished;     // current process already finished
      logic        found;
      logic        all_done;     // done count equals processes in use
      logic        last_seq;
      logic        in_last;
      logic        out_busy;
   } dp_stat_type;

endpackage
`default_nettype wire

[rtl/bsa_ram.sv]
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module bsa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule
`default_nettype wire

[rtl/bsa_datapath.sv]
// Datapath: tables, request buffer, work vector, counters and output register.
`timescale 1ns / 1ps
`default_nettype none
module bsa_datapath #(
   parameter int MAX_PROCS  = 16,
   parameter int MAX_RES    = 8,
   parameter int COUNT_BITS = 8
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire bsa_pkg::dp_cmd_type  cmd_i,
   output bsa_pkg::dp_stat_type      stat_o,
   input  wire logic [2:0]           req_command,
   input  wire logic [3:0]           req_process_index,
   input  wire logic [2:0]           req_resource_index,
   input  wire logic [7:0]           req_amount,
   input  wire logic                 req_in_last,
   input  wire logic                 csr_write,
   input  wire logic [0:0]           csr_index,
   input  wire logic [4:0]           csr_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [2:0]                rsp_status,
   output logic [3:0]                rsp_seq_process,
   output logic                      rsp_out_last
);
   import bsa_pkg::*;

   localparam int PB = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
   localparam int RB = (MAX_RES > 1) ? $clog2(MAX_RES) : 1;
   localparam int CELLS = MAX_PROCS * MAX_RES;
   localparam int AB = $clog2(CELLS);
   localparam int WB = COUNT_BITS + PB + 1;   // work vector grows by sums
   localparam int NB = PB + 1;

   // Configuration, clamped on use.
   logic [4:0] proc_cnt_ff, proc_cnt_in;
   logic [3:0] res_cnt_ff, res_cnt_in;
   logic [NB-1:0] np;
   logic [RB:0]   nr;

   always_comb begin
      proc_cnt_in = proc_cnt_ff;
      res_cnt_in  = res_cnt_ff;
      if (csr_write) begin
         if (csr_index == CSR_PROCESS_COUNT) proc_cnt_in = csr_data;
         else res_cnt_in = csr_data[3:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         proc_cnt_ff <= 5'd5;
         res_cnt_ff  <= 4'd3;
      end else begin
         proc_cnt_ff <= proc_cnt_in;
         res_cnt_ff  <= res_cnt_in;
      end
   end

   always_comb begin
      if (proc_cnt_ff == 5'd0) np = NB'(1);
      else if (32'(proc_cnt_ff) > MAX_PROCS) np = NB'(MAX_PROCS);
      else np = NB'(proc_cnt_ff);
      if (res_cnt_ff == 4'd0) nr = (RB+1)'(1);
      else if (32'(res_cnt_ff) > MAX_RES) nr = (RB+1)'(MAX_RES);
      else nr = (RB+1)'(res_cnt_ff);
   end

   // Captured transaction.
   command_type      cmd_ff;
   logic [3:0]       pidx_ff;
   logic [2:0]       ridx_ff;
   logic [COUNT_BITS-1:0] amt_ff;
   logic             last_ff;

   always_ff @(posedge clock) begin
      if (cmd_i.capture_req) begin
         cmd_ff  <= command_type'(req_command);
         pidx_ff <= req_process_index;
         ridx_ff <= req_resource_index;
         amt_ff  <= COUNT_BITS'(req_amount);
         last_ff <= req_in_last;
      end
   end

   // Counters.
   logic [PB-1:0] proc_ff;
   logic [RB-1:0] res_ff;
   logic [NB-1:0] done_ff;
   logic [PB-1:0] seq_ff;
   logic [AB-1:0] clr_ff;
   logic fits_ff, found_ff;

   // Small vectors: valid-bit style arrays in flip-flops.
   logic [COUNT_BITS-1:0] avail_ff [MAX_RES];
   logic [COUNT_BITS-1:0] rbuf_ff  [MAX_RES];
   logic [WB-1:0]         work_ff  [MAX_RES];
   logic [MAX_PROCS-1:0]  fin_ff;
   logic [PB-1:0]         order_ff [MAX_PROCS];

   // Table RAM address.
   logic [PB-1:0] a_proc;
   logic [AB-1:0] addr;
   logic          ridx_ok, pidx_ok;
   logic          max_we, alloc_we;
   logic [COUNT_BITS-1:0] max_wd, alloc_wd, max_rd, alloc_rd;
   logic [COUNT_BITS-1:0] need, req_cur;

   assign ridx_ok = 32'(ridx_ff) < MAX_RES;
   assign pidx_ok = {1'b0, pidx_ff} < 5'(np);
   assign a_proc = (cmd_i.do_load || cmd_i.use_req_proc) ? PB'(pidx_ff) : proc_ff;

   always_comb begin
      if (cmd_i.clr_write)
         addr = clr_ff;
      else if (cmd_i.do_load)
         addr = AB'(32'(PB'(pidx_ff)) * MAX_RES + 32'(RB'(ridx_ff)));
      else
         addr = AB'(32'(a_proc) * MAX_RES + 32'(res_ff));
   end

   assign req_cur = rbuf_ff[res_ff];
   assign need = (alloc_rd > max_rd) ? '0 : max_rd - alloc_rd;

   always_comb begin
      max_we   = 1'b0;
      alloc_we = 1'b0;
      max_wd   = amt_ff;
      alloc_wd = amt_ff;
      if (cmd_i.clr_write) begin
         max_we   = 1'b1;
         alloc_we = 1'b1;
         max_wd   = '0;
         alloc_wd = '0;
      end else if (cmd_i.do_load && pidx_ok && ridx_ok) begin
         max_we   = (cmd_ff == CMD_LOAD_MAX);
         alloc_we = (cmd_ff == CMD_LOAD_ALLOC);
      end else if (cmd_i.trial_write) begin
         alloc_we = 1'b1;
         alloc_wd = alloc_rd + req_cur;
      end else if (cmd_i.roll_write) begin
         alloc_we = 1'b1;
         alloc_wd = alloc_rd - req_cur;
      end
   end

   bsa_ram #(.WIDTH(COUNT_BITS), .DEPTH(CELLS)) u_max (
      .clock(clock), .wr_en(max_we), .addr(addr), .wr_data(max_wd), .rd_data(max_rd)
   );
   bsa_ram #(.WIDTH(COUNT_BITS), .DEPTH(CELLS)) u_alloc (
      .clock(clock), .wr_en(alloc_we), .addr(addr), .wr_data(alloc_wd),
      .rd_data(alloc_rd)
   );

   logic fits_now;
   assign fits_now = {{(WB-COUNT_BITS){1'b0}}, need} <= work_ff[res_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_RES; i++) begin
            avail_ff[i] <= '0;
            rbuf_ff[i]  <= '0;
         end
         fin_ff  <= '0;
         proc_ff <= '0;
         res_ff  <= '0;
         done_ff <= '0;
         seq_ff  <= '0;
         clr_ff  <= '0;
         fits_ff <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         if (cmd_i.clr_write) clr_ff <= clr_ff + 1'b1;
         if (cmd_i.do_load && cmd_ff == CMD_LOAD_AVAIL && ridx_ok)
            avail_ff[RB'(ridx_ff)] <= amt_ff;
         if (cmd_i.clr_req_buf)
            for (int i = 0; i < MAX_RES; i++) rbuf_ff[i] <= '0;
         else if (cmd_i.do_load && cmd_ff == CMD_REQUEST && ridx_ok)
            rbuf_ff[RB'(ridx_ff)] <= amt_ff;
         if (cmd_i.trial_write) avail_ff[res_ff] <= avail_ff[res_ff] - req_cur;
         if (cmd_i.roll_write)  avail_ff[res_ff] <= avail_ff[res_ff] + req_cur;
         if (cmd_i.res_clr) res_ff <= '0;
         else if (cmd_i.res_inc) res_ff <= res_ff + 1'b1;
         if (cmd_i.proc_clr) proc_ff <= '0;
         else if (cmd_i.proc_inc) proc_ff <= proc_ff + 1'b1;
         if (cmd_i.fin_clr) begin
            fin_ff  <= '0;
            done_ff <= '0;
         end else if (cmd_i.fin_set) begin
            fin_ff[proc_ff] <= 1'b1;
            done_ff <= done_ff + 1'b1;
         end
         if (cmd_i.fits_clr) fits_ff <= 1'b1;
         else if (cmd_i.fits_cmp) fits_ff <= fits_ff & fits_now;
         if (cmd_i.found_clr) found_ff <= 1'b0;
         else if (cmd_i.fin_set) found_ff <= 1'b1;
         if (cmd_i.seq_clr) seq_ff <= '0;
         else if (cmd_i.seq_inc) seq_ff <= seq_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_i.work_init) work_ff[res_ff] <= WB'(avail_ff[res_ff]);
      if (cmd_i.work_add)  work_ff[res_ff] <= work_ff[res_ff] + WB'(alloc_rd);
      if (cmd_i.fin_set)   order_ff[done_ff[PB-1:0]] <= proc_ff;
   end

   // Output register.
   logic       valid_ff;
   logic [2:0] status_ff;
   logic [3:0] seqp_ff;
   logic       olast_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (cmd_i.out_load) begin
         valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_i.out_load) begin
         status_ff <= cmd_i.out_status;
         if (cmd_i.out_from_seq) begin
            seqp_ff  <= 4'(order_ff[seq_ff]);
            olast_ff <= (NB'(seq_ff) + 1'b1 == np);
         end else begin
            seqp_ff  <= 4'd0;
            olast_ff <= 1'b1;
         end
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_seq_process = seqp_ff;
   assign rsp_out_last    = olast_ff;

   always_comb begin
      stat_o.cmd       = cmd_ff;
      stat_o.clr_done  = (clr_ff == AB'(CELLS - 1));
      stat_o.proc_bad  = !pidx_ok;
      stat_o.last_res  = ((RB+1)'(res_ff) + 1'b1 == nr);
      stat_o.last_proc = (NB'(proc_ff) + 1'b1 == np);
      stat_o.need_bad  = req_cur > need;
      stat_o.avail_bad = req_cur > avail_ff[res_ff];
      stat_o.fits      = fits_ff;
      stat_o.fits_now  = fits_now;
      stat_o.finished  = fin_ff[proc_ff];
      stat_o.found     = found_ff;
      stat_o.all_done  = (done_ff == np);
      stat_o.last_seq  = (NB'(seq_ff) + 1'b1 == np);
      stat_o.in_last   = last_ff;
      stat_o.out_busy  = valid_ff && rsp_stall;
   end

   // The safe sequence never lists a process twice.
   a_no_double_finish: assert property (@(posedge clock) disable iff (reset)
      cmd_i.fin_set |-> !fin_ff[proc_ff]) else $error("process finished twice");
   // A process is only appended while fewer than the processes in use are done.
   a_done_bound: assert property (@(posedge clock) disable iff (reset)
      cmd_i.fin_set |-> done_ff < np) else $error("done count overflow");
   // A result is never loaded over one that is still stalled.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd_i.out_load |-> !(valid_ff && rsp_stall)) else $error("result overwritten");
endmodule
`default_nettype wire

[rtl/bsa_controller.sv]
// Controller: state machine sequencing loads, request checks and the safety search.
`timescale 1ns / 1ps
`default_nettype none
module bsa_controller (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire bsa_pkg::dp_stat_type stat_i,
   output bsa_pkg::dp_cmd_type       cmd_o
);
   import bsa_pkg::*;

   fsm_state_type state_ff, state_in;
   logic from_req_ff, from_req_in;   // search was started by a request
   status_type single_ff, single_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_CLEAR;
         from_req_ff <= 1'b0;
         single_ff   <= ST_STORED;
      end else begin
         state_ff    <= state_in;
         from_req_ff <= from_req_in;
         single_ff   <= single_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      from_req_in = from_req_ff;
      single_in   = single_ff;
      cmd_o       = '0;
      cmd_o.out_status = ST_STORED;
      req_stall   = 1'b1;
      case (state_ff)
         S_CLEAR: begin   // zero both tables, one cell per cycle
            cmd_o.clr_write = 1'b1;
            if (stat_i.clr_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_stall = 1'b0;
            cmd_o.capture_req = req_valid;
            if (req_valid) state_in = S_LOAD;
         end
         S_LOAD: begin
            cmd_o.res_clr = 1'b1;
            single_in = ST_STORED;
            state_in  = S_SINGLE;
            case (stat_i.cmd)
               CMD_LOAD_MAX, CMD_LOAD_ALLOC: begin
                  cmd_o.do_load = 1'b1;
                  if (stat_i.proc_bad) single_in = ST_BAD_PROC;
               end
               CMD_LOAD_AVAIL: cmd_o.do_load = 1'b1;
               CMD_SAFETY: begin
                  from_req_in = 1'b0;
                  state_in    = S_SRCH_INIT;
               end
               CMD_REQUEST: begin
                  cmd_o.do_load = 1'b1;
                  if (stat_i.in_last) begin
                     if (stat_i.proc_bad) begin
                        cmd_o.clr_req_buf = 1'b1;
                        single_in = ST_BAD_PROC;
                     end else begin
                        state_in = S_CHK_RD;
                     end
                  end
               end
               default: ;
            endcase
         end
         S_CHK_RD: begin   // RAM read of (request process, res) in flight
            cmd_o.use_req_proc = 1'b1;
            state_in = S_CHK_NEED;
         end
         S_CHK_NEED: begin
            cmd_o.use_req_proc = 1'b1;
            if (stat_i.need_bad) begin
               cmd_o.clr_req_buf = 1'b1;
               single_in = ST_EXCEEDS;
               state_in  = S_SINGLE;
            end else if (stat_i.last_res) begin
               cmd_o.res_clr = 1'b1;
               state_in = S_CHK_AVAIL;
            end else begin
               cmd_o.res_inc = 1'b1;
               state_in = S_CHK_RD;
            end
         end
         S_CHK_AVAIL: begin
            cmd_o.use_req_proc = 1'b1;
            if (stat_i.avail_bad) begin
               cmd_o.clr_req_buf = 1'b1;
               single_in = ST_BLOCKED;
               state_in  = S_SINGLE;
            end else if (stat_i.last_res) begin
               cmd_o.res_clr = 1'b1;
               state_in = S_TRIAL;
            end else begin
               cmd_o.res_inc = 1'b1;
            end
         end
         S_TRIAL: begin   // read each class, then write its commit
            cmd_o.use_req_proc = 1'b1;
            if (!from_req_ff) begin
               from_req_in = 1'b1;
            end else begin
               from_req_in = 1'b0;
               cmd_o.trial_write = 1'b1;
               if (stat_i.last_res) begin
                  cmd_o.res_clr = 1'b1;
                  from_req_in = 1'b1;
                  state_in = S_SRCH_INIT;
               end else begin
                  cmd_o.res_inc = 1'b1;
               end
            end
         end
         S_SRCH_INIT: begin
            cmd_o.work_init = 1'b1;
            if (stat_i.last_res) begin
               cmd_o.res_clr   = 1'b1;
               cmd_o.proc_clr  = 1'b1;
               cmd_o.fin_clr   = 1'b1;
               cmd_o.found_clr = 1'b1;
               cmd_o.fits_clr  = 1'b1;
               state_in = S_SRCH_RD;
            end else begin
               cmd_o.res_inc = 1'b1;
            end
         end
         S_SRCH_RD: begin
            if (stat_i.finished) state_in = S_SRCH_NEXT;
            else state_in = S_SRCH_CMP;
         end
         S_SRCH_CMP: begin
            cmd_o.fits_cmp = 1'b1;
            if (!stat_i.fits_now) begin
               cmd_o.res_clr = 1'b1;
               state_in = S_SRCH_NEXT;
            end else if (stat_i.last_res) begin
               cmd_o.res_clr = 1'b1;
               state_in = S_SRCH_ADD_RD;
            end else begin
               cmd_o.res_inc = 1'b1;
               state_in = S_SRCH_RD;
            end
         end
         S_SRCH_ADD_RD: state_in = S_SRCH_ADD;
         S_SRCH_ADD: begin
            cmd_o.work_add = 1'b1;
            if (stat_i.last_res) begin
               cmd_o.res_clr = 1'b1;
               cmd_o.fin_set = 1'b1;
               state_in = S_SRCH_NEXT;
            end else begin
               cmd_o.res_inc = 1'b1;
               state_in = S_SRCH_ADD_RD;
            end
         end
         S_SRCH_NEXT: begin
            cmd_o.fits_clr = 1'b1;
            if (stat_i.found) begin
               // first fit found: rescan from the first process
               cmd_o.found_clr = 1'b1;
               cmd_o.proc_clr  = 1'b1;
               state_in = S_SRCH_RD;
            end else if (stat_i.last_proc) begin
               state_in = S_SRCH_END;
            end else begin
               cmd_o.proc_inc = 1'b1;
               state_in = S_SRCH_RD;
            end
         end
         S_SRCH_END: begin
            cmd_o.seq_clr = 1'b1;
            cmd_o.res_clr = 1'b1;
            if (stat_i.all_done) begin
               state_in = S_SEQ_OUT;
            end else if (from_req_ff) begin
               from_req_in = 1'b0;
               state_in = S_ROLLBACK;
            end else begin
               single_in = ST_UNSAFE;
               state_in  = S_SINGLE;
            end
         end
         S_ROLLBACK: begin
            cmd_o.use_req_proc = 1'b1;
            if (!from_req_ff) begin
               from_req_in = 1'b1;
            end else begin
               from_req_in = 1'b0;
               cmd_o.roll_write = 1'b1;
               if (stat_i.last_res) begin
                  single_in = ST_UNSAFE;
                  state_in  = S_SEQ_RD;
               end else begin
                  cmd_o.res_inc = 1'b1;
               end
            end
         end
         S_SEQ_RD: begin
            // rollback done: clear buffer and report
            cmd_o.clr_req_buf = 1'b1;
            state_in = S_SINGLE;
         end
         S_SEQ_OUT: begin
            if (!stat_i.out_busy) begin
               cmd_o.out_load     = 1'b1;
               cmd_o.out_status   = ST_SAFE;
               cmd_o.out_from_seq = 1'b1;
               cmd_o.seq_inc      = 1'b1;
               if (stat_i.last_seq) begin
                  if (from_req_ff) cmd_o.clr_req_buf = 1'b1;
                  from_req_in = 1'b0;
                  state_in = S_IDLE;
               end
            end
         end
         S_SINGLE: begin
            if (!stat_i.out_busy) begin
               cmd_o.out_load   = 1'b1;
               cmd_o.out_status = single_ff;
               state_in = S_IDLE;
            end
         end
         S_WAIT_OUT: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // Transactions are taken only in the idle state.
   a_take_idle: assert property (@(posedge clock) disable iff (reset)
      !req_stall |-> state_ff == S_IDLE) else $error("input taken while busy");
   // The search compare state never writes tables.
   a_no_write_in_search: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SRCH_CMP) |-> !(cmd_o.trial_write || cmd_o.roll_write))
      else $error("table written during search");
   // The input stays stalled while the tables are being cleared.
   a_clear_stalls: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> req_stall) else $error("input taken while clearing");
endmodule
`default_nettype wire

[rtl/bankers_safety_allocator.sv]
// Top level of the banker's safety allocator: controller and datapath.
`timescale 1ns / 1ps
`default_nettype none
// A load or buffered request element passes the load and single-result states before
// its result is registered; no new transaction is taken until the block is idle again.
// A request check tests need class by class, then available class by class, and then
// commits each class with a table read followed by a write. The safety search reads the
// tables through the one RAM address; safe sequences leave at one transaction per cycle
// unless the receiver stalls. Synchronous reset clears state, then zeroes both tables.
module bankers_safety_allocator #(
   parameter int MAX_PROCS  = 16,
   parameter int MAX_RES    = 8,
   parameter int COUNT_BITS = 8
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [2:0] req_command,
   input  wire logic [3:0] req_process_index,
   input  wire logic [2:0] req_resource_index,
   input  wire logic [7:0] req_amount,
   input  wire logic       req_in_last,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [2:0]      rsp_status,
   output logic [3:0]      rsp_seq_process,
   output logic            rsp_out_last,
   input  wire logic       csr_write,
   input  wire logic [0:0] csr_index,
   input  wire logic [4:0] csr_data
);
   import bsa_pkg::*;

   // The controller drives the datapath only through these two structures.
   dp_cmd_type  dp_cmd;
   dp_stat_type dp_stat;

   bsa_controller u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .stat_i(dp_stat), .cmd_o(dp_cmd)
   );

   bsa_datapath #(.MAX_PROCS(MAX_PROCS), .MAX_RES(MAX_RES), .COUNT_BITS(COUNT_BITS))
   u_dp (
      .clock(clock), .reset(reset), .cmd_i(dp_cmd), .stat_o(dp_stat),
      .req_command(req_command), .req_process_index(req_process_index),
      .req_resource_index(req_resource_index), .req_amount(req_amount),
      .req_in_last(req_in_last), .csr_write(csr_write), .csr_index(csr_index),
      .csr_data(csr_data), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_status(rsp_status), .rsp_seq_process(rsp_seq_process),
      .rsp_out_last(rsp_out_last)
   );

   // Every transaction accepted gets its result: the input stalls after each one taken.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall) else $error("second transaction taken");
   // A stalled result stays valid and unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_status)
         && $stable(rsp_seq_process) && $stable(rsp_out_last)))
      else $error("stalled result changed");
   // Only defined status codes leave the block.
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= ST_BAD_PROC) else $error("undefined status");
endmodule
`default_nettype wire

[dv/bsa_checker.sv]
// Checker for the banker's safety allocator: follows both channels, predicts results and compares them.
`timescale 1ns / 1ps
module bsa_checker (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic       req_stall,
   input  wire logic [2:0] req_command,
   input  wire logic [3:0] req_process_index,
   input  wire logic [2:0] req_resource_index,
   input  wire logic [7:0] req_amount,
   input  wire logic       req_in_last,
   input  wire logic       rsp_valid,
   input  wire logic       rsp_stall,
   input  wire logic [2:0] rsp_status,
   input  wire logic [3:0] rsp_seq_process,
   input  wire logic       rsp_out_last,
   input  wire logic       csr_write,
   input  wire logic [0:0] csr_index,
   input  wire logic [4:0] csr_data,
   output int              fail_count,
   output int              pending
);
   import bsa_pkg::*;

   typedef struct {
      status_type status;
      logic [3:0] seq_process;
      logic       out_last;
   } grant_result_type;

   grant_result_type awaited_results[$];

   logic [4:0] proc_setting;
   logic [3:0] res_setting;
   logic [7:0] claim_tbl [16][8];
   logic [7:0] held_tbl [16][8];
   logic [7:0] free_units [8];
   logic [7:0] pending_request [8];
   logic [3:0] grant_order [16];

   function automatic int procs_in_use();
      if (proc_setting == 0) return 1;
      if (proc_setting > 16) return 16;
      return int'(proc_setting);
   endfunction

   function automatic int classes_in_use();
      if (res_setting == 0) return 1;
      if (res_setting > 8) return 8;
      return int'(res_setting);
   endfunction

   function automatic int need_units(int p, int r);
      if (held_tbl[p][r] > claim_tbl[p][r]) return 0;
      return int'(claim_tbl[p][r]) - int'(held_tbl[p][r]);
   endfunction

   function automatic void expect_single(status_type s);
      grant_result_type e;
      e.status      = s;
      e.seq_process = '0;
      e.out_last    = 1'b1;
      awaited_results.push_back(e);
   endfunction

   function automatic void expect_sequence();
      grant_result_type e;
      int np;
      np = procs_in_use();
      for (int k = 0; k < np; k++) begin
         e.status      = ST_SAFE;
         e.seq_process = grant_order[k];
         e.out_last    = (k == np - 1);
         awaited_results.push_back(e);
      end
   endfunction

   // Repeatedly finish the first unfinished process whose need fits the work vector.
   function automatic bit system_is_safe();
      int work [8];
      bit done_flag [16];
      int np, nr, done_count;
      bit progress, fits;
      np = procs_in_use();
      nr = classes_in_use();
      done_count = 0;
      for (int r = 0; r < 8; r++) work[r] = (r < nr) ? int'(free_units[r]) : 0;
      for (int p = 0; p < 16; p++) done_flag[p] = 1'b0;
      do begin
         progress = 1'b0;
         for (int p = 0; p < np && !progress; p++) begin
            if (!done_flag[p]) begin
               fits = 1'b1;
               for (int r = 0; r < nr; r++)
                  if (need_units(p, r) > work[r]) fits = 1'b0;
               if (fits) begin
                  for (int r = 0; r < nr; r++) work[r] += int'(held_tbl[p][r]);
                  done_flag[p] = 1'b1;
                  grant_order[done_count] = 4'(p);
                  done_count++;
                  progress = 1'b1;
               end
            end
         end
      end while (progress);
      return done_count == np;
   endfunction

   function automatic void evaluate_grant(int p);
      logic [7:0] asked [8];
      int nr;
      nr = classes_in_use();
      for (int r = 0; r < 8; r++) begin
         asked[r] = pending_request[r];
         pending_request[r] = '0;
      end
      if (p >= procs_in_use()) begin
         expect_single(ST_BAD_PROC);
         return;
      end
      for (int r = 0; r < nr; r++)
         if (int'(asked[r]) > need_units(p, r)) begin
            expect_single(ST_EXCEEDS);
            return;
         end
      for (int r = 0; r < nr; r++)
         if (asked[r] > free_units[r]) begin
            expect_single(ST_BLOCKED);
            return;
         end
      for (int r = 0; r < nr; r++) begin
         free_units[r]  -= asked[r];
         held_tbl[p][r] += asked[r];
      end
      if (!system_is_safe()) begin
         for (int r = 0; r < nr; r++) begin
            free_units[r]  += asked[r];
            held_tbl[p][r] -= asked[r];
         end
         expect_single(ST_UNSAFE);
      end else begin
         expect_sequence();
      end
   endfunction

   function automatic void predict_transaction(logic [2:0] cmd, logic [3:0] p, logic [2:0] r,
                                               logic [7:0] amt, logic last);
      case (cmd)
         CMD_LOAD_MAX, CMD_LOAD_ALLOC: begin
            if (int'(p) >= procs_in_use()) begin
               expect_single(ST_BAD_PROC);
            end else begin
               if (cmd == CMD_LOAD_MAX) claim_tbl[p][r] = amt;
               else held_tbl[p][r] = amt;
               expect_single(ST_STORED);
            end
         end
         CMD_LOAD_AVAIL: begin
            free_units[r] = amt;
            expect_single(ST_STORED);
         end
         CMD_SAFETY: begin
            if (system_is_safe()) expect_sequence();
            else expect_single(ST_UNSAFE);
         end
         CMD_REQUEST: begin
            pending_request[r] = amt;
            if (!last) expect_single(ST_STORED);
            else evaluate_grant(int'(p));
         end
         default: expect_single(ST_STORED);
      endcase
   endfunction

   task automatic report_mismatch(string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      fail_count++;
   endtask

   always @(posedge clock) begin
      grant_result_type e;
      if (reset) begin
         proc_setting = 5'd5;
         res_setting  = 4'd3;
         for (int p = 0; p < 16; p++)
            for (int r = 0; r < 8; r++) begin
               claim_tbl[p][r] = '0;
               held_tbl[p][r]  = '0;
            end
         for (int r = 0; r < 8; r++) begin
            free_units[r]      = '0;
            pending_request[r] = '0;
         end
         awaited_results.delete();
      end else begin
         if (csr_write) begin
            if (csr_index == CSR_PROCESS_COUNT) proc_setting = csr_data;
            else res_setting = csr_data[3:0];
         end
         // The block holds one transaction at a time, so inputs are predicted first.
         if (req_valid && !req_stall)
            predict_transaction(req_command, req_process_index, req_resource_index,
                                req_amount, req_in_last);
         if (rsp_valid && !rsp_stall) begin
            if (awaited_results.size() == 0) begin
               report_mismatch($sformatf("unexpected result status %0d", rsp_status));
            end else begin
               e = awaited_results.pop_front();
               if (rsp_status !== e.status)
                  report_mismatch($sformatf("status %0d, expected %0d", rsp_status, e.status));
               if (rsp_seq_process !== e.seq_process)
                  report_mismatch($sformatf("seq_process %0d, expected %0d",
                                            rsp_seq_process, e.seq_process));
               if (rsp_out_last !== e.out_last)
                  report_mismatch($sformatf("out_last %0b, expected %0b",
                                            rsp_out_last, e.out_last));
            end
         end
      end
      pending = awaited_results.size();
   end

endmodule

[dv/tb_bankers_safety_allocator.sv]
// Testbench top for the banker's safety allocator: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_bankers_safety_allocator;
   import bsa_pkg::*;

   // The watchdog limit must outlast a full search over sixteen processes and eight
   // classes as well as the receiver's long hold-off; this value is ample for both.
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int HOLD_CYCLES    = 400;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [2:0] req_command;
   logic [3:0] req_process_index;
   logic [2:0] req_resource_index;
   logic [7:0] req_amount;
   logic       req_in_last;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [2:0] rsp_status;
   logic [3:0] rsp_seq_process;
   logic       rsp_out_last;
   logic       csr_write;
   logic [0:0] csr_index;
   logic [4:0] csr_data;

   int fail_count;
   int pending;
   int random_items;
   int quiet_cycles;
   bit idle_on;
   bit hold_go;

   bankers_safety_allocator dut (
      .clock, .reset,
      .req_valid, .req_stall, .req_command, .req_process_index, .req_resource_index,
      .req_amount, .req_in_last,
      .rsp_valid, .rsp_stall, .rsp_status, .rsp_seq_process, .rsp_out_last,
      .csr_write, .csr_index, .csr_data
   );

   bsa_checker u_checker (
      .clock, .reset,
      .req_valid, .req_stall, .req_command, .req_process_index, .req_resource_index,
      .req_amount, .req_in_last,
      .rsp_valid, .rsp_stall, .rsp_status, .rsp_seq_process, .rsp_out_last,
      .csr_write, .csr_index, .csr_data,
      .fail_count, .pending
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // The receiver stalls at random while idling is enabled. When asked, it holds off
   // for a long stretch of its own so that the block fills and pushes back on the sender.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_go) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_go = 1'b0;
         end
         rsp_stall <= idle_on && ($urandom_range(99) < 25);
      end
   end

   // The watchdog counts cycles in which no transaction moves on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Offers one transaction and returns once it has been accepted. The valid stays
   // high into the next call unless a random gap is inserted first.
   task automatic send(logic [2:0] cmd, logic [3:0] p, logic [2:0] r, logic [7:0] amt,
                       logic last);
      if (idle_on && $urandom_range(99) < 25) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_command        <= cmd;
      req_process_index  <= p;
      req_resource_index <= r;
      req_amount         <= amt;
      req_in_last        <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      random_items++;
   endtask

   // Drains every awaited result and lets the block settle before the registers change.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_setting(logic [0:0] idx, logic [4:0] value);
      wait_drained();
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   // Sends a request for a process, one element per top class in a random run, last marked.
   task automatic send_request(logic [3:0] p, int nr, int top);
      int count;
      count = $urandom_range(1, nr);
      for (int k = 0; k < count; k++)
         send(CMD_REQUEST, p, 3'(k + nr - count), 8'($urandom_range(0, top)),
              k == count - 1);
   endtask

   // One random phase: new sizes, freshly loaded tables, then a run of requests with
   // a little noise. Claims are kept small so that grants, blocks and rollbacks all occur.
   task automatic random_phase(bit with_hold);
      int np, nr, m;
      logic [3:0] p;
      np = ($urandom_range(9) == 0) ? $urandom_range(6, 16) : $urandom_range(1, 5);
      nr = ($urandom_range(9) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
      write_setting(CSR_PROCESS_COUNT, 5'(np));
      write_setting(CSR_RESOURCE_COUNT, 5'(nr));
      for (int i = 0; i < np; i++)
         for (int r = 0; r < nr; r++) begin
            m = $urandom_range(0, 9);
            send(CMD_LOAD_MAX, 4'(i), 3'(r), 8'(m), 1'($urandom_range(1)));
            send(CMD_LOAD_ALLOC, 4'(i), 3'(r),
                 ($urandom_range(19) == 0) ? 8'($urandom_range(255)) :
                                             8'($urandom_range(0, m)),
                 1'($urandom_range(1)));
         end
      for (int r = 0; r < nr; r++)
         send(CMD_LOAD_AVAIL, 4'($urandom_range(15)), 3'(r), 8'($urandom_range(0, 12)),
              1'($urandom_range(1)));
      if (with_hold) hold_go = 1'b1;
      repeat ($urandom_range(6, 14)) begin
         p = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(0, np - 1));
         case ($urandom_range(9))
            0:       send(CMD_SAFETY, p, 3'($urandom_range(7)), 8'($urandom),
                          1'($urandom_range(1)));
            1:       send(3'($urandom_range(0, 7)), 4'($urandom_range(15)),
                          3'($urandom_range(7)), 8'($urandom), 1'($urandom_range(1)));
            default: send_request(p, nr, 3);
         endcase
      end
   endtask

   initial begin
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_command        = '0;
      req_process_index  = '0;
      req_resource_index = '0;
      req_amount         = '0;
      req_in_last        = 1'b0;
      csr_write          = 1'b0;
      csr_index          = '0;
      csr_data           = '0;
      idle_on            = 1'b0;
      hold_go            = 1'b0;
      random_items       = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset leaves every table at zero, so with the largest sizes in force the
      // system is trivially safe: a full sixteen-entry sequence.
      write_setting(CSR_PROCESS_COUNT, 5'd16);
      write_setting(CSR_RESOURCE_COUNT, 5'd8);
      send(CMD_SAFETY, 4'd0, 3'd0, 8'd0, 1'b0);

      // Directed part: three processes over two classes, a small textbook set-up.
      write_setting(CSR_PROCESS_COUNT, 5'd3);
      write_setting(CSR_RESOURCE_COUNT, 5'd2);
      send(CMD_LOAD_MAX, 4'd0, 3'd0, 8'd4, 1'b0);
      send(CMD_LOAD_MAX, 4'd0, 3'd1, 8'd2, 1'b0);
      send(CMD_LOAD_MAX, 4'd1, 3'd0, 8'd2, 1'b0);
      send(CMD_LOAD_MAX, 4'd1, 3'd1, 8'd2, 1'b0);
      send(CMD_LOAD_MAX, 4'd2, 3'd0, 8'd3, 1'b0);
      send(CMD_LOAD_MAX, 4'd2, 3'd1, 8'd3, 1'b0);
      send(CMD_LOAD_ALLOC, 4'd0, 3'd0, 8'd1, 1'b0);
      send(CMD_LOAD_ALLOC, 4'd1, 3'd0, 8'd1, 1'b0);
      send(CMD_LOAD_ALLOC, 4'd1, 3'd1, 8'd1, 1'b0);
      send(CMD_LOAD_ALLOC, 4'd2, 3'd1, 8'd1, 1'b0);
      send(CMD_LOAD_AVAIL, 4'd15, 3'd0, 8'd2, 1'b0);
      send(CMD_LOAD_AVAIL, 4'd7, 3'd1, 8'd1, 1'b1);
      // A grantable request, sent as a buffered element and then the last one.
      send(CMD_REQUEST, 4'd1, 3'd0, 8'd1, 1'b0);
      send(CMD_REQUEST, 4'd1, 3'd1, 8'd0, 1'b1);
      // More than the process still needs.
      send(CMD_REQUEST, 4'd1, 3'd0, 8'd255, 1'b1);
      // Within need but more than is free.
      send(CMD_REQUEST, 4'd0, 3'd0, 8'd1, 1'b0);
      send(CMD_REQUEST, 4'd0, 3'd1, 8'd2, 1'b1);
      // Affordable, but leaves the system unsafe, so it is rolled back.
      send(CMD_REQUEST, 4'd0, 3'd0, 8'd1, 1'b0);
      send(CMD_REQUEST, 4'd0, 3'd1, 8'd1, 1'b1);
      // Requests and loads for processes outside the ones in use.
      send(CMD_REQUEST, 4'd15, 3'd7, 8'd0, 1'b1);
      send(CMD_LOAD_MAX, 4'd9, 3'd7, 8'd255, 1'b1);
      // Unused commands are answered and ignored.
      send(3'd5, 4'd15, 3'd7, 8'd255, 1'b1);
      send(3'd7, 4'd0, 3'd0, 8'd0, 1'b0);
      // An allocation above the claim means no further need.
      send(CMD_LOAD_ALLOC, 4'd2, 3'd0, 8'd255, 1'b0);
      send(CMD_SAFETY, 4'd0, 3'd0, 8'd0, 1'b0);
      // Zero and oversized register values clamp to the nearest legal size.
      write_setting(CSR_PROCESS_COUNT, 5'd0);
      write_setting(CSR_RESOURCE_COUNT, 5'd0);
      send(CMD_SAFETY, 4'd0, 3'd0, 8'd0, 1'b1);
      write_setting(CSR_PROCESS_COUNT, 5'd31);
      write_setting(CSR_RESOURCE_COUNT, 5'd15);
      send(CMD_SAFETY, 4'd0, 3'd0, 8'd0, 1'b1);

      // Random part: the first phase runs without idling, the second holds the receiver off.
      random_items = 0;
      random_phase(1'b0);
      idle_on = 1'b1;
      random_phase(1'b1);
      while (random_items < 260) random_phase(1'b0);

      wait_drained();
      repeat (50) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

[bankers_safety_allocator.f]
rtl/bsa_pkg.sv
rtl/bsa_ram.sv
rtl/bsa_datapath.sv
rtl/bsa_controller.sv
rtl/bankers_safety_allocator.sv
dv/bsa_checker.sv
dv/tb_bankers_safety_allocator.sv
